// ===== hdl/rps_pkg.sv =====
package rps_pkg;

  // Field widths.
  localparam int FIT_W   = 32;
  localparam int ID_W    = 16;
  localparam int POINT_W = 48;
  localparam int TOTAL_W = 38;
  localparam int ENTRY_W = FIT_W + ID_W;

  // Operation codes carried by mode.
  localparam logic [1:0] MODE_INSERT   = 2'd0;
  localparam logic [1:0] MODE_ROULETTE = 2'd1;
  localparam logic [1:0] MODE_RANKED   = 2'd2;
  localparam logic [1:0] MODE_READ     = 2'd3;

  // Result codes carried by outcome.
  localparam logic [2:0] OUT_STORED   = 3'd0;
  localparam logic [2:0] OUT_EVICTED  = 3'd1;
  localparam logic [2:0] OUT_DISCARD  = 3'd2;
  localparam logic [2:0] OUT_SELECTED = 3'd3;
  localparam logic [2:0] OUT_EMPTY    = 3'd4;
  localparam logic [2:0] OUT_CLAMPED  = 3'd5;

  // Configuration register indexes.
  localparam logic CFG_RANK_BASE = 1'b0;
  localparam logic CFG_RANK_STEP = 1'b1;

  localparam logic [31:0] RANK_BASE_RST = 32'd327680;
  localparam logic [31:0] RANK_STEP_RST = 32'd65536;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LAUNCH = 5'b00010,
    S_SCAN   = 5'b00100,
    S_PLACE  = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

endpackage

// ===== hdl/rps_ram.sv =====
module rps_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/ranked_population_selector_unit.sv =====
// Ranked population selector: keeps up to CAPACITY individuals sorted by
// descending Q16.16 fitness in one table memory.
// Input channel (in_valid/in_ready) takes one word: mode, fitness, item_id,
// point and rank. Mode 0 inserts, mode 1 makes a roulette selection, mode 2
// a linear rank selection, mode 3 reads the entry at a given rank.
// Output channel (out_valid/out_ready) returns one word per input word with
// outcome, out_id, out_fitness, out_rank and the count and total after it.
// Configuration channel (cfg_valid/cfg_ready) writes rank_base (index 0) or
// rank_step (index 1); it is always ready and should be used while idle.
// An insert walks up from the worst entry, shifting each one down a slot;
// a selection walks down from the best entry. The memory's single read
// port visits one entry per cycle, and one word is worked on at a time.
// A finished word waits in the output register; the next input word is
// accepted meanwhile, and it holds its result until that register is free.
// Reset empties the table and restores the default rank scores.
module ranked_population_selector_unit #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [31:0] fitness,
  input  logic [15:0] item_id,
  input  logic [47:0] point,
  input  logic [5:0]  rank,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  outcome,
  output logic [15:0] out_id,
  output logic [31:0] out_fitness,
  output logic [5:0]  out_rank,
  output logic [6:0]  count,
  output logic [37:0] total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = IW + 1;
  localparam int SW = 32 + CW + 1;

  rps_pkg::state_t state;

  // Configuration and table bookkeeping.
  logic [31:0] rank_base, rank_step;
  logic [CW-1:0] held_count;
  logic [rps_pkg::TOTAL_W-1:0] fitness_sum;

  // Latched input word.
  logic [1:0] mode_q;
  logic [31:0] fit_q;
  logic [15:0] id_q;
  logic [5:0] rank_q;
  logic [47:0] left_q;

  // Scan sequencing.
  logic [IW-1:0] rd_idx, cur, pos;
  logic [CW-1:0] rd_left;
  logic rd_up, dv;
  logic [SW-1:0] score_q;
  logic ev_flag;
  logic [31:0] ev_fit;
  logic [15:0] ev_id;

  // Pending result.
  logic [2:0] res_outcome;
  logic [15:0] res_id;
  logic [31:0] res_fit;
  logic [IW-1:0] res_rank;

  // Memory port signals.
  logic we;
  logic [IW-1:0] waddr;
  logic [rps_pkg::ENTRY_W-1:0] wdata, rdata;
  logic [31:0] rfit;
  logic [15:0] rid;

  assign rfit = rdata[rps_pkg::ENTRY_W-1:rps_pkg::ID_W];
  assign rid  = rdata[rps_pkg::ID_W-1:0];

  // Evaluation terms of the current scan entry.
  logic full, first, last, take_shift;
  logic [47:0] score_w;
  logic [CW+31:0] prod;

  assign full  = (held_count == CW'(CAPACITY));
  assign first = full && (cur == IW'(CAPACITY - 1));
  assign last  = (cur == IW'(held_count - CW'(1)));
  assign score_w = (mode_q == rps_pkg::MODE_RANKED) ? 48'(score_q) : 48'(rfit);
  assign prod = rank_step * (held_count - CW'(1));
  assign take_shift = (state == rps_pkg::S_SCAN) && dv &&
                      (mode_q == rps_pkg::MODE_INSERT) && (rfit < fit_q) && !first;

  // Table writes: shift one slot toward the worst end, or place the newcomer.
  always_comb begin
    we = take_shift || (state == rps_pkg::S_PLACE);
    if (state == rps_pkg::S_PLACE) begin
      waddr = pos;
      wdata = {fit_q, id_q};
    end else begin
      waddr = cur + IW'(1);
      wdata = rdata;
    end
  end

  rps_ram #(
    .WIDTH(rps_pkg::ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(rd_idx),
    .rdata(rdata)
  );

  assign in_ready  = (state == rps_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= rps_pkg::S_IDLE;
      out_valid   <= 1'b0;
      dv          <= 1'b0;
      held_count  <= '0;
      fitness_sum <= '0;
      rank_base   <= rps_pkg::RANK_BASE_RST;
      rank_step   <= rps_pkg::RANK_STEP_RST;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          rps_pkg::CFG_RANK_BASE: rank_base <= cfg_data;
          rps_pkg::CFG_RANK_STEP: rank_step <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      // Issue one read a cycle while reads remain.
      if (state == rps_pkg::S_SCAN) begin
        if (rd_left != '0) begin
          cur     <= rd_idx;
          dv      <= 1'b1;
          rd_left <= rd_left - CW'(1);
          rd_idx  <= rd_up ? rd_idx + IW'(1) : rd_idx - IW'(1);
        end else begin
          dv <= 1'b0;
        end
      end

      case (state)
        rps_pkg::S_IDLE: begin
          if (in_valid) begin
            mode_q <= mode;
            fit_q  <= fitness;
            id_q   <= item_id;
            left_q <= point;
            rank_q <= rank;
            state  <= rps_pkg::S_LAUNCH;
          end
        end

        rps_pkg::S_LAUNCH: begin
          dv      <= 1'b0;
          ev_flag <= 1'b0;
          score_q <= SW'(rank_base) + SW'(prod);
          case (mode_q)
            rps_pkg::MODE_INSERT: begin
              if (held_count == '0) begin
                pos   <= '0;
                state <= rps_pkg::S_PLACE;
              end else begin
                rd_idx  <= IW'(held_count - CW'(1));
                rd_left <= held_count;
                rd_up   <= 1'b0;
                state   <= rps_pkg::S_SCAN;
              end
            end
            rps_pkg::MODE_READ: begin
              if (32'(rank_q) < 32'(held_count)) begin
                rd_idx  <= IW'(rank_q);
                rd_left <= CW'(1);
                rd_up   <= 1'b1;
                state   <= rps_pkg::S_SCAN;
              end else begin
                res_outcome <= rps_pkg::OUT_EMPTY;
                res_id      <= '0;
                res_fit     <= '0;
                res_rank    <= '0;
                state       <= rps_pkg::S_OUT;
              end
            end
            default: begin
              if (held_count == '0) begin
                res_outcome <= rps_pkg::OUT_EMPTY;
                res_id      <= '0;
                res_fit     <= '0;
                res_rank    <= '0;
                state       <= rps_pkg::S_OUT;
              end else begin
                rd_idx  <= '0;
                rd_left <= held_count;
                rd_up   <= 1'b1;
                state   <= rps_pkg::S_SCAN;
              end
            end
          endcase
        end

        // Evaluate the entry whose read data has just arrived.
        rps_pkg::S_SCAN: begin
          if (dv) begin
            case (mode_q)
              rps_pkg::MODE_INSERT: begin
                if (rfit >= fit_q) begin
                  if (first) begin
                    res_outcome <= rps_pkg::OUT_DISCARD;
                    res_id      <= id_q;
                    res_fit     <= fit_q;
                    res_rank    <= '0;
                    state       <= rps_pkg::S_OUT;
                  end else begin
                    pos   <= cur + IW'(1);
                    state <= rps_pkg::S_PLACE;
                  end
                end else begin
                  if (first) begin
                    ev_flag <= 1'b1;
                    ev_fit  <= rfit;
                    ev_id   <= rid;
                  end
                  if (cur == '0) begin
                    pos   <= '0;
                    state <= rps_pkg::S_PLACE;
                  end
                end
              end
              rps_pkg::MODE_READ: begin
                res_outcome <= rps_pkg::OUT_SELECTED;
                res_id      <= rid;
                res_fit     <= rfit;
                res_rank    <= cur;
                state       <= rps_pkg::S_OUT;
              end
              default: begin
                res_id   <= rid;
                res_fit  <= rfit;
                res_rank <= cur;
                if (score_w > left_q) begin
                  res_outcome <= rps_pkg::OUT_SELECTED;
                  state       <= rps_pkg::S_OUT;
                end else if (last) begin
                  res_outcome <= rps_pkg::OUT_CLAMPED;
                  state       <= rps_pkg::S_OUT;
                end
                left_q  <= left_q - score_w;
                score_q <= score_q - SW'(rank_step);
              end
            endcase
          end
        end

        // Place the newcomer and update the running sum, and the count unless an entry was evicted.
        rps_pkg::S_PLACE: begin
          res_rank <= pos;
          if (ev_flag) begin
            res_outcome <= rps_pkg::OUT_EVICTED;
            res_id      <= ev_id;
            res_fit     <= ev_fit;
            fitness_sum <= fitness_sum - rps_pkg::TOTAL_W'(ev_fit)
                           + rps_pkg::TOTAL_W'(fit_q);
          end else begin
            res_outcome <= rps_pkg::OUT_STORED;
            res_id      <= id_q;
            res_fit     <= fit_q;
            held_count  <= held_count + CW'(1);
            fitness_sum <= fitness_sum + rps_pkg::TOTAL_W'(fit_q);
          end
          state <= rps_pkg::S_OUT;
        end

        // Hand the word to the output register once it is free.
        rps_pkg::S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            outcome     <= res_outcome;
            out_id      <= res_id;
            out_fitness <= res_fit;
            out_rank    <= 6'(res_rank);
            count       <= 7'(held_count);
            total       <= fitness_sum;
            state       <= rps_pkg::S_IDLE;
          end
        end

        default: state <= rps_pkg::S_IDLE;
      endcase
    end
  end

endmodule
